// ----- rtl/frsnl_pkg.sv -----
// Shared constants for the Fresnel reflectance pipeline.
`timescale 1ns / 1ps
package frsnl_pkg;
   localparam int CB_DEF   = 16;
   localparam int IOR_W    = 16;
   localparam int REFL_W   = 16;
   localparam int TERM_W   = 34;
   localparam int SUM_W    = 35;
   localparam int C_W      = 31;
   localparam int RAD_W    = 62;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int DIV_W    = 47;
   localparam int QUO_W    = 17;
   localparam int SQ_W     = 2 * QUO_W;
   localparam logic [REFL_W-1:0] REFL_ONE = 16'd32768;
   localparam logic signed [SUM_W-1:0] ONE_Q30 = 35'sd1073741824;
endpackage

// ----- rtl/frsnl_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module frsnl_sqrt #(
   parameter int IN_W   = frsnl_pkg::RAD_W,
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [IN_W-1:0]       in_rad,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [IN_W/2-1:0]     out_root,
   output logic [SIDE_W-1:0]     out_side
);
   localparam int STEPS = IN_W / 2;
   localparam int RW    = STEPS + 2;

   logic              valid_ff [STEPS];
   logic [RW-1:0]     rem_ff   [STEPS];
   logic [RW-1:0]     rem_in   [STEPS];
   logic [STEPS-1:0]  root_ff  [STEPS];
   logic [STEPS-1:0]  root_in  [STEPS];
   logic [IN_W-1:0]   rad_ff   [STEPS];
   logic [IN_W-1:0]   rad_in   [STEPS];
   logic [SIDE_W-1:0] side_ff  [STEPS];

   always_comb begin
      logic [RW-1:0]    p_rem;
      logic [STEPS-1:0] p_root;
      logic [IN_W-1:0]  p_rad;
      logic [RW+1:0]    sh;
      logic [RW+1:0]    trial;
      for (int i = 0; i < STEPS; i++) begin
         if (i == 0) begin
            p_rem  = '0;
            p_root = '0;
            p_rad  = in_rad;
         end else begin
            p_rem  = rem_ff[i-1];
            p_root = root_ff[i-1];
            p_rad  = rad_ff[i-1];
         end
         sh    = {p_rem, p_rad[IN_W-1 -: 2]};
         trial = (RW+2)'({p_root, 2'b01});
         if (sh >= trial) begin
            rem_in[i]  = RW'(sh - trial);
            root_in[i] = {p_root[STEPS-2:0], 1'b1};
         end else begin
            rem_in[i]  = RW'(sh);
            root_in[i] = {p_root[STEPS-2:0], 1'b0};
         end
         rad_in[i] = p_rad << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STEPS; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < STEPS; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < STEPS; i++) side_ff[i] <= side_ff[i-1];
         for (int i = 0; i < STEPS; i++) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            rad_ff[i]  <= rad_in[i];
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];
endmodule

// ----- rtl/frsnl_div.sv -----
// Two-lane pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module frsnl_div #(
   parameter int W      = frsnl_pkg::DIV_W,
   parameter int Q      = frsnl_pkg::QUO_W,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [W-1:0]      in_num [2],
   input  logic [W-1:0]      in_den [2],
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [Q-1:0]      out_quo [2],
   output logic [SIDE_W-1:0] out_side
);
   logic              valid_ff [Q];
   logic [SIDE_W-1:0] side_ff  [Q];
   logic [W-1:0]      rem_ff   [Q][2];
   logic [W-1:0]      rem_in   [Q][2];
   logic [W-1:0]      den_ff   [Q][2];
   logic [W-1:0]      den_in   [Q][2];
   logic [Q-1:0]      quo_ff   [Q][2];
   logic [Q-1:0]      quo_in   [Q][2];

   always_comb begin
      logic [W:0]   t;
      logic [W-1:0] d;
      logic [Q-1:0] pq;
      for (int i = 0; i < Q; i++) begin
         for (int l = 0; l < 2; l++) begin
            if (i == 0) begin
               t  = {1'b0, in_num[l]};
               d  = in_den[l];
               pq = '0;
            end else begin
               t  = {rem_ff[i-1][l], 1'b0};
               d  = den_ff[i-1][l];
               pq = quo_ff[i-1][l];
            end
            if (t >= {1'b0, d}) begin
               rem_in[i][l] = W'(t - {1'b0, d});
               quo_in[i][l] = {pq[Q-2:0], 1'b1};
            end else begin
               rem_in[i][l] = W'(t);
               quo_in[i][l] = {pq[Q-2:0], 1'b0};
            end
            den_in[i][l] = d;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Q; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < Q; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < Q; i++) side_ff[i] <= side_ff[i-1];
         for (int i = 0; i < Q; i++) begin
            for (int l = 0; l < 2; l++) begin
               rem_ff[i][l] <= rem_in[i][l];
               den_ff[i][l] <= den_in[i][l];
               quo_ff[i][l] <= quo_in[i][l];
            end
         end
      end
   end

   assign out_valid  = valid_ff[Q-1];
   assign out_quo[0] = quo_ff[Q-1][0];
   assign out_quo[1] = quo_ff[Q-1][1];
   assign out_side   = side_ff[Q-1];
endmodule

// ----- rtl/fresnel_reflectance_top.sv -----
// Fresnel reflectance top level: dot product, Snell test, sqrt, ratios, output register.
`timescale 1ns / 1ps
// Takes one word per cycle while the result side is not stalled and returns one result
// word per input word, in order. The depth comes
// from the 31-step square root pipeline and the 17-step dual divider for the two
// Fresnel ratios; the remaining twelve stages hold the multiplies and compares.
// A stall on the result side holds the whole pipeline; nothing is dropped.
module fresnel_reflectance_top #(
   parameter int COMPONENT_BITS = frsnl_pkg::CB_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [COMPONENT_BITS-1:0]  req_incident_x,
   input  logic signed [COMPONENT_BITS-1:0]  req_incident_y,
   input  logic signed [COMPONENT_BITS-1:0]  req_incident_z,
   input  logic signed [COMPONENT_BITS-1:0]  req_normal_x,
   input  logic signed [COMPONENT_BITS-1:0]  req_normal_y,
   input  logic signed [COMPONENT_BITS-1:0]  req_normal_z,
   input  logic [frsnl_pkg::IOR_W-1:0]       req_index_of_refraction,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [frsnl_pkg::REFL_W-1:0]      rsp_reflectance,
   output logic                              rsp_total_internal
);
   import frsnl_pkg::*;

   localparam int CB    = COMPONENT_BITS;
   localparam int PF    = 2 * (CB - 2);
   localparam int SH_DN = (PF > 30) ? PF - 30 : 0;
   localparam int SH_UP = (PF > 30) ? 0 : 30 - PF;
   localparam int S1_W  = 1 + IOR_W + 2 * IOR_W + C_W;

   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // stage A: component products in Q.30
   logic signed [CB-1:0]     inc [3];
   logic signed [CB-1:0]     nrm [3];
   logic signed [2*CB-1:0]   prod [3];
   logic signed [TERM_W-1:0] term_in [3];
   logic signed [TERM_W-1:0] term_a_ff [3];
   logic [IOR_W-1:0]         ior_a_ff;
   logic                     v_a_ff;

   assign inc[0] = req_incident_x;
   assign inc[1] = req_incident_y;
   assign inc[2] = req_incident_z;
   assign nrm[0] = req_normal_x;
   assign nrm[1] = req_normal_y;
   assign nrm[2] = req_normal_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod[i]    = inc[i] * nrm[i];
         term_in[i] = TERM_W'(prod[i] >>> SH_DN) <<< SH_UP;
      end
   end

   // stage B: sum, clamp, medium swap
   logic signed [SUM_W-1:0] dot_in;
   logic [C_W-1:0]          c_b_in;
   logic [IOR_W-1:0]        a_b_in, b_b_in;
   logic [C_W-1:0]          c_b_ff;
   logic [IOR_W-1:0]        a_b_ff, b_b_ff;
   logic                    v_b_ff;

   always_comb begin
      dot_in = SUM_W'(term_a_ff[0]) + SUM_W'(term_a_ff[1]) + SUM_W'(term_a_ff[2]);
      if (dot_in > ONE_Q30) dot_in = ONE_Q30;
      if (dot_in < -ONE_Q30) dot_in = -ONE_Q30;
      if (dot_in > 0) begin
         a_b_in = ior_a_ff;
         b_b_in = IOR_W'(4096);
         c_b_in = C_W'(dot_in);
      end else begin
         a_b_in = IOR_W'(4096);
         b_b_in = ior_a_ff;
         c_b_in = C_W'(-dot_in);
      end
   end

   // stage C: squares
   logic [2*C_W-1:0]   cc_c_ff;
   logic [2*IOR_W-1:0] aa_c_ff, bb_c_ff;
   logic [IOR_W-1:0]   a_c_ff;
   logic [C_W-1:0]     c_c_ff;
   logic               v_c_ff;

   // stage D: sin^2
   logic [C_W-1:0]     s_d_ff;
   logic [2*IOR_W-1:0] aa_d_ff, bb_d_ff;
   logic [IOR_W-1:0]   a_d_ff;
   logic [C_W-1:0]     c_d_ff;
   logic               v_d_ff;

   // stage E: Snell terms
   logic [RAD_W:0]     lhs_e_ff;
   logic [RAD_W-1:0]   rhs_e_ff;
   logic [2*IOR_W-1:0] bb_e_ff;
   logic [IOR_W-1:0]   a_e_ff;
   logic [C_W-1:0]     c_e_ff;
   logic               v_e_ff;

   // stage F: total internal reflection test
   logic               tir_f_in;
   logic [RAD_W-1:0]   rad_f_in;
   logic [RAD_W-1:0]   rad_f_ff;
   logic [S1_W-1:0]    side_f_ff;
   logic               v_f_ff;

   assign tir_f_in = lhs_e_ff >= {1'b0, rhs_e_ff};
   assign rad_f_in = tir_f_in ? '0 : rhs_e_ff - lhs_e_ff[RAD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
         v_c_ff <= 1'b0;
         v_d_ff <= 1'b0;
         v_e_ff <= 1'b0;
         v_f_ff <= 1'b0;
      end else if (en) begin
         v_a_ff <= req_valid;
         v_b_ff <= v_a_ff;
         v_c_ff <= v_b_ff;
         v_d_ff <= v_c_ff;
         v_e_ff <= v_d_ff;
         v_f_ff <= v_e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) term_a_ff[i] <= term_in[i];
         ior_a_ff  <= (req_index_of_refraction == '0) ? IOR_W'(1) : req_index_of_refraction;
         c_b_ff    <= c_b_in;
         a_b_ff    <= a_b_in;
         b_b_ff    <= b_b_in;
         cc_c_ff   <= c_b_ff * c_b_ff;
         aa_c_ff   <= a_b_ff * a_b_ff;
         bb_c_ff   <= b_b_ff * b_b_ff;
         a_c_ff    <= a_b_ff;
         c_c_ff    <= c_b_ff;
         s_d_ff    <= C_W'(1 << 30) - C_W'(cc_c_ff >> 30);
         aa_d_ff   <= aa_c_ff;
         bb_d_ff   <= bb_c_ff;
         a_d_ff    <= a_c_ff;
         c_d_ff    <= c_c_ff;
         lhs_e_ff  <= (RAD_W+1)'(aa_d_ff) * (RAD_W+1)'(s_d_ff);
         rhs_e_ff  <= {bb_d_ff, 30'b0};
         bb_e_ff   <= bb_d_ff;
         a_e_ff    <= a_d_ff;
         c_e_ff    <= c_d_ff;
         rad_f_ff  <= rad_f_in;
         side_f_ff <= {tir_f_in, a_e_ff, bb_e_ff, c_e_ff};
      end
   end

   // square root: T = b * cos(t) in Q.27
   logic               v_sq;
   logic [ROOT_W-1:0]  t_sq;
   logic [S1_W-1:0]    side_sq;

   frsnl_sqrt #(.IN_W(RAD_W), .SIDE_W(S1_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_f_ff),
      .in_rad    (rad_f_ff),
      .in_side   (side_f_ff),
      .out_valid (v_sq),
      .out_root  (t_sq),
      .out_side  (side_sq)
   );

   logic               tir_sq;
   logic [IOR_W-1:0]   a_sq;
   logic [2*IOR_W-1:0] bb_sq;
   logic [C_W-1:0]     c_sq;
   assign {tir_sq, a_sq, bb_sq, c_sq} = side_sq;

   // stage G: ratio products
   logic [2*IOR_W+C_W-1:0] xs_g_ff;
   logic [IOR_W+C_W-1:0]   at_g_ff, ac_g_ff;
   logic [ROOT_W-1:0]      t_g_ff;
   logic                   tir_g_ff, v_g_ff;

   // stage H: numerators and denominators
   logic [63:0]      den_s_h_ff;
   logic [62:0]      num_s_h_ff;
   logic [DIV_W:0]   den_p_h_ff;
   logic [DIV_W-1:0] num_p_h_ff;
   logic             tir_h_ff, v_h_ff;
   logic [62:0]      xs_ext, ys_ext;
   logic [DIV_W:0]   xp_ext, yp_ext;

   assign xs_ext = xs_g_ff;
   assign ys_ext = 63'({at_g_ff, 15'b0});
   assign xp_ext = (DIV_W+1)'(ac_g_ff);
   assign yp_ext = (DIV_W+1)'({t_g_ff, 15'b0});

   // stage I: normalize amount, zero denominators
   logic [4:0]       k_in;
   logic [4:0]       k_i_ff;
   logic [63:0]      den_s_i_ff;
   logic [62:0]      num_s_i_ff;
   logic [DIV_W-1:0] den_p_i_ff, num_p_i_ff;
   logic             zs_i_ff, zp_i_ff, tir_i_ff, v_i_ff;

   always_comb begin
      k_in = '0;
      for (int i = DIV_W; i < 64; i++) begin
         if (den_s_h_ff[i]) k_in = 5'(i - DIV_W + 1);
      end
   end

   // stage J: normalize
   logic [DIV_W-1:0] num_j_ff [2];
   logic [DIV_W-1:0] den_j_ff [2];
   logic [2:0]       side_j_ff;
   logic             v_j_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_g_ff <= 1'b0;
         v_h_ff <= 1'b0;
         v_i_ff <= 1'b0;
         v_j_ff <= 1'b0;
      end else if (en) begin
         v_g_ff <= v_sq;
         v_h_ff <= v_g_ff;
         v_i_ff <= v_h_ff;
         v_j_ff <= v_i_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xs_g_ff     <= bb_sq * c_sq;
         at_g_ff     <= a_sq * t_sq;
         ac_g_ff     <= a_sq * c_sq;
         t_g_ff      <= t_sq;
         tir_g_ff    <= tir_sq;
         den_s_h_ff  <= 64'(xs_ext) + 64'(ys_ext);
         num_s_h_ff  <= (xs_ext >= ys_ext) ? xs_ext - ys_ext : ys_ext - xs_ext;
         den_p_h_ff  <= xp_ext + yp_ext;
         num_p_h_ff  <= DIV_W'((xp_ext >= yp_ext) ? xp_ext - yp_ext : yp_ext - xp_ext);
         tir_h_ff    <= tir_g_ff;
         k_i_ff      <= k_in;
         den_s_i_ff  <= den_s_h_ff;
         num_s_i_ff  <= num_s_h_ff;
         den_p_i_ff  <= DIV_W'(den_p_h_ff);
         num_p_i_ff  <= num_p_h_ff;
         zs_i_ff     <= den_s_h_ff == '0;
         zp_i_ff     <= den_p_h_ff == '0;
         tir_i_ff    <= tir_h_ff;
         num_j_ff[0] <= DIV_W'(num_s_i_ff >> k_i_ff);
         den_j_ff[0] <= DIV_W'(den_s_i_ff >> k_i_ff);
         num_j_ff[1] <= num_p_i_ff;
         den_j_ff[1] <= den_p_i_ff;
         side_j_ff   <= {tir_i_ff, zs_i_ff, zp_i_ff};
      end
   end

   // ratio quotients in Q.16
   logic             v_dv;
   logic [QUO_W-1:0] quo_dv [2];
   logic [2:0]       side_dv;

   frsnl_div #(.W(DIV_W), .Q(QUO_W), .SIDE_W(3)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_j_ff),
      .in_num    (num_j_ff),
      .in_den    (den_j_ff),
      .in_side   (side_j_ff),
      .out_valid (v_dv),
      .out_quo   (quo_dv),
      .out_side  (side_dv)
   );

   // stage K: squares of the ratios
   logic [QUO_W-1:0] qs_in, qp_in;
   logic [SQ_W-1:0]  sqs_k_ff, sqp_k_ff;
   logic             tir_k_ff, v_k_ff;

   assign qs_in = side_dv[1] ? QUO_W'(65536) : quo_dv[0];
   assign qp_in = side_dv[0] ? QUO_W'(65536) : quo_dv[1];

   // stage L: output register
   logic [SQ_W:0]       sum_in;
   logic [QUO_W-1:0]    avg_in;
   logic [REFL_W-1:0]   refl_in;
   logic                rsp_valid_ff;
   logic [REFL_W-1:0]   rsp_refl_ff;
   logic                rsp_tir_ff;

   always_comb begin
      sum_in = (SQ_W+1)'(sqs_k_ff) + (SQ_W+1)'(sqp_k_ff) + (SQ_W+1)'(1 << 17);
      avg_in = QUO_W'(sum_in >> 18);
      if (tir_k_ff || avg_in > QUO_W'(REFL_ONE)) refl_in = REFL_ONE;
      else refl_in = REFL_W'(avg_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_k_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_k_ff       <= v_dv;
         rsp_valid_ff <= v_k_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqs_k_ff    <= qs_in * qs_in;
         sqp_k_ff    <= qp_in * qp_in;
         tir_k_ff    <= side_dv[2];
         rsp_refl_ff <= refl_in;
         rsp_tir_ff  <= tir_k_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reflectance    = rsp_refl_ff;
   assign rsp_total_internal = rsp_tir_ff;
endmodule

// ----- rtl/frsnl_checker.sv -----
// Port-level checks for the Fresnel reflectance block, bound to the top level.
`timescale 1ns / 1ps
module frsnl_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [frsnl_pkg::REFL_W-1:0] rsp_reflectance,
   input logic                         rsp_total_internal
);
   import frsnl_pkg::*;

   a_tir_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_total_internal |-> rsp_reflectance == REFL_ONE)
      else $error("total internal word without full reflectance");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_reflectance <= REFL_ONE)
      else $error("reflectance above one");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reflectance))
      else $error("stalled result word changed");
endmodule

bind fresnel_reflectance_top frsnl_checker u_frsnl_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_reflectance    (rsp_reflectance),
   .rsp_total_internal (rsp_total_internal)
);

// ----- sim/fresnel_reflectance_top_tb.sv -----
// Testbench for fresnel_reflectance_top: random and directed ray hits checked against a predictor.
`timescale 1ns / 1ps
class refl_scoreboard;
   logic [15:0] want_refl [1024];
   logic        want_tir [1024];
   int          wr_cnt;
   int          rd_cnt;
   int          errors;
   int          checked;
   int          tir_seen;

   function new();
      wr_cnt = 0;
      rd_cnt = 0;
      errors = 0;
      checked = 0;
      tir_seen = 0;
   endfunction

   function int pending();
      return wr_cnt - rd_cnt;
   endfunction

   function void add_expected(logic [15:0] refl, logic tir);
      want_refl[wr_cnt % 1024] = refl;
      want_tir[wr_cnt % 1024] = tir;
      wr_cnt++;
   endfunction

   function logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
         if (v >= res + bt) begin
            v = v - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   function logic [63:0] fresnel_ratio(logic [63:0] x, logic [63:0] y);
      logic [63:0] num;
      logic [63:0] den;
      num = (x > y) ? x - y : y - x;
      den = x + y;
      if (den == 0) return 64'd65536;
      while (den >= (64'd1 << 47)) begin
         num = num >> 1;
         den = den >> 1;
      end
      return (num << 16) / den;
   endfunction

   // 16-bit components: product is Q.28, scale up by 4 to Q.30
   function void note_hit(logic signed [15:0] ix, logic signed [15:0] iy,
                          logic signed [15:0] iz, logic signed [15:0] nx,
                          logic signed [15:0] ny, logic signed [15:0] nz,
                          logic [15:0] ior_in);
      logic signed [63:0] dot;
      logic [63:0] ior, a, b, c, s, lhs, rhs, t, qs, qp, sum;
      dot = (64'(ix) * 64'(nx) + 64'(iy) * 64'(ny) + 64'(iz) * 64'(nz)) * 4;
      if (dot > 64'sd1073741824) dot = 64'sd1073741824;
      if (dot < -64'sd1073741824) dot = -64'sd1073741824;
      ior = (ior_in == 0) ? 64'd1 : 64'(ior_in);
      if (dot > 0) begin
         a = ior; b = 4096; c = dot;
      end else begin
         a = 4096; b = ior; c = -dot;
      end
      s = (64'd1 << 30) - ((c * c) >> 30);
      lhs = a * a * s;
      rhs = (b * b) << 30;
      if (lhs >= rhs) begin
         add_expected(16'd32768, 1'b1);
         return;
      end
      t = isqrt(rhs - lhs);
      qs = fresnel_ratio(b * b * c, (a * t) << 15);
      qp = fresnel_ratio(a * c, t << 15);
      sum = (qs * qs + qp * qp + (64'd1 << 17)) >> 18;
      if (sum > 32768) sum = 32768;
      add_expected(sum[15:0], 1'b0);
   endfunction

   function void check_result(logic [15:0] refl, logic tir);
      logic [15:0] er;
      logic et;
      checked++;
      if (tir) tir_seen++;
      if (pending() == 0) begin
         $display("%0t: unexpected word refl=%0d tir=%0d", $time, refl, tir);
         errors++;
         return;
      end
      er = want_refl[rd_cnt % 1024];
      et = want_tir[rd_cnt % 1024];
      rd_cnt++;
      if (er !== refl) begin
         $display("%0t: reflectance expected %0d actual %0d", $time, er, refl);
         errors++;
      end
      if (et !== tir) begin
         $display("%0t: total_internal expected %0d actual %0d", $time, et, tir);
         errors++;
      end
   endfunction
endclass

module fresnel_reflectance_top_tb;
   import frsnl_pkg::*;

   localparam int WATCHDOG = 20000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [15:0] req_incident_x = '0, req_incident_y = '0, req_incident_z = '0;
   logic signed [15:0] req_normal_x = '0, req_normal_y = '0, req_normal_z = '0;
   logic [IOR_W-1:0] req_index_of_refraction = 16'd4096;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [REFL_W-1:0] rsp_reflectance;
   logic rsp_total_internal;

   refl_scoreboard sb = new();
   int send_idle = 0;
   int recv_idle = 0;
   bit hold_rsp = 0;
   int idle_cycles = 0;

   fresnel_reflectance_top dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_hit(req_incident_x, req_incident_y, req_incident_z,
                        req_normal_x, req_normal_y, req_normal_z,
                        req_index_of_refraction);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_reflectance, rsp_total_internal);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   always @(negedge clock)
      rsp_ready <= !reset && !hold_rsp && ($urandom_range(99) >= recv_idle);

   // leaves valid high after acceptance; the next call or drain() updates it
   task automatic send_hit(logic signed [15:0] ix, logic signed [15:0] iy,
                           logic signed [15:0] iz, logic signed [15:0] nx,
                           logic signed [15:0] ny, logic signed [15:0] nz,
                           logic [15:0] ior);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_incident_x <= ix; req_incident_y <= iy; req_incident_z <= iz;
      req_normal_x <= nx; req_normal_y <= ny; req_normal_z <= nz;
      req_index_of_refraction <= ior;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_comp();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(33000) - 16500);
         2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         default: return 16'($urandom_range(16384) - 8192);
      endcase
   endfunction

   function automatic logic [15:0] rand_ior();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(4095));
         default: return 16'($urandom_range(8192, 4096));
      endcase
   endfunction

   task automatic send_random(int n);
      logic signed [15:0] v[6];
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(2) == 0) begin
            // unit-length axis hits, random sign, keeps cosi near +-1
            foreach (v[k]) v[k] = '0;
            v[$urandom_range(2)] = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            v[3 + $urandom_range(2)] = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            v[$urandom_range(5)] = rand_comp();
         end else begin
            foreach (v[k]) v[k] = rand_comp();
         end
         send_hit(v[0], v[1], v[2], v[3], v[4], v[5], rand_ior());
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed corners
      send_hit(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd4096);
      send_hit(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0);
      send_hit(-16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'd6144);
      send_hit(16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'd6144);
      send_hit(16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'd0);
      send_hit(-16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'd0);
      send_hit(-16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'd2048);
      send_hit(16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 16'sd0, 16'sd0, 16'd6144);
      send_hit(16'sd5000, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'd8192);
      send_hit(16'sd1000, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'hffff);
      send_hit(-16'sd1000, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'hffff);
      send_hit(-16'sd200, 16'sd0, 16'sd16000, 16'sd16384, 16'sd0, 16'sd0, 16'd6144);
      send_hit(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'd5000);
      send_hit(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'd5000);
      send_hit(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'hffff);
      send_hit(16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'd4097);
      send_hit(-16'sd3000, -16'sd3000, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'd1);
      send_hit(-16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'd4096);
      send_hit(16'h5555, 16'h2aaa, 16'h5555, 16'h2aaa, 16'h5555, 16'h2aaa, 16'haaaa);
      send_hit(-16'sh5556, 16'sh2aaa, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'h5555);
      drain();
      send_idle = 10; recv_idle = 65;
      send_random(230);
      // long result stall while input keeps coming
      hold_rsp = 1;
      fork
         begin repeat (300) @(negedge clock); hold_rsp = 0; end
         send_random(90);
      join
      drain();
      send_idle = 65; recv_idle = 10;
      send_random(200);
      drain();
      send_idle = 0; recv_idle = 0;
      send_random(200);
      drain();
      repeat (100) @(negedge clock);
      $display("Checked %0d results, %0d with total internal reflection, %0d mismatches.",
               sb.checked, sb.tir_seen, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule

// ----- files.f -----
rtl/frsnl_pkg.sv
rtl/frsnl_sqrt.sv
rtl/frsnl_div.sv
rtl/fresnel_reflectance_top.sv
rtl/frsnl_checker.sv
sim/fresnel_reflectance_top_tb.sv
